// ----- src/esc_pkg.sv -----
// Package: types and constants for the event start probability pipeline
`timescale 1ns / 1ps

package esc_pkg;

    // request kinds, picked from the event index
    localparam logic [1:0] K_STEP = 2'd0;
    localparam logic [1:0] K_UNI  = 2'd1;
    localparam logic [1:0] K_TRI  = 2'd2;
    localparam logic [1:0] K_NORM = 2'd3;

    localparam int IN_W  = 208;
    localparam int OUT_W = 24;

    localparam logic [23:0] DELAY_RST = 24'd10000000;

    // stage map
    localparam int ST_S0  = 0;
    localparam int ST_CLS = 1;
    localparam int ST_TRI = 2;
    localparam int ST_D1  = 3;
    localparam int N_D1   = 23;
    localparam int ST_PST = ST_D1 + N_D1;
    localparam int ST_DEN = ST_PST + 1;
    localparam int ST_D2  = ST_DEN + 1;
    localparam int N_D2   = 31;
    localparam int ST_HRN = ST_D2 + N_D2;
    localparam int N_HRN  = 5;
    localparam int ST_CLP = ST_HRN + N_HRN;
    localparam int ST_G   = ST_CLP + 1;
    localparam int ST_TAY = ST_G + 1;
    localparam int N_TAY  = 10;
    localparam int ST_SHF = ST_TAY + 2 * N_TAY;
    localparam int ST_E   = ST_SHF + 1;
    localparam int ST_OUT = ST_E + 1;
    localparam int NST    = ST_OUT + 1;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [30:0] ONE_Q30   = 31'd1073741824;
    localparam logic [29:0] INV_SQRT2 = 30'd759250125;
    localparam logic [28:0] P_Q30     = 29'd351748265;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;

    localparam logic signed [31:0] A5_Q30 = 32'sd1139675401;
    // added after each Horner product: a4, a3, a2, a1, then nothing
    localparam logic signed [31:0] HRN_ADD [N_HRN] = '{
        -32'sd1560310108, 32'sd1526231383, -32'sd305476044, 32'sd273621191, 32'sd0
    };

    // exact floor(y/k) for y < 2^31: (y * RECIP[k]) >> RSHF[k]
    localparam logic [31:0] RECIP [1:10] = '{
        32'd2147483648, 32'd2147483648, 32'd2863311531, 32'd2147483648, 32'd3435973837,
        32'd2863311531, 32'd2454267027, 32'd2147483648, 32'd3817748708, 32'd3435973837
    };
    localparam int RSHF [1:10] = '{31, 32, 33, 33, 34, 34, 34, 34, 35, 35};

    typedef struct packed {
        logic [1:0]  kind;
        logic        done;   // result already final
        logic [16:0] res;
        logic        inv;    // tri: upper half; normal: t >= mean
        logic        sat;    // |z| saturated at 8
        logic [48:0] d;      // t - ideal start
        logic [47:0] mag;    // |t - mean|
        logic [39:0] sig;
        logic [23:0] ev;
        logic [63:0] rem;
        logic [47:0] dvs;
        logic [30:0] quo;
        logic [22:0] x;
        logic [25:0] u;
        logic [31:0] acc;
        logic [6:0]  ip;
        logic [29:0] g;
        logic [30:0] h;
        logic [30:0] p;
    } t_item;

endpackage

// ----- src/event_start_cdf_unit.sv -----
// Top level: pipelined start probability of an advertising event, Q1.16 result
`timescale 1ns / 1ps

// Channel   Dir  Width  Contents (low bit first)
// s_axis    in   208    event_index, eval_time, ideal_start, mean_start, std_dev
// m_axis    out  24     cdf_value
// i_cfg     in   24     max_random_delay, written when i_cfg_we is high
//
// One request per cycle. The stages include the two restoring dividers
// (23 and 31 quotient bits, one bit per stage) and the ten-term exp series.
// The last stage is the output register; all stages advance together and
// halt only while it holds a result that m_axis does not take.
// Reset (synchronous, active low) clears the valid bits and loads the
// delay width with 10000000 ns.

module event_start_cdf_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // event_index[19:0], eval_time[67:20], ideal_start[115:68],
    // mean_start[163:116], std_dev[203:164], zero pad
    input  logic [esc_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // cdf_value[16:0], zero pad
    output logic [esc_pkg::OUT_W-1:0]    m_axis_tdata,
    input  logic                         i_cfg_we,
    input  logic [23:0]                  i_cfg_wdata
);

    // ---------------------------------------------------------------
    // stage functions
    // ---------------------------------------------------------------

    // operand capture: both time differences and sigma floor
    function automatic esc_pkg::t_item f_s0(input logic [esc_pkg::IN_W-1:0] td);
        esc_pkg::t_item o;
        logic [19:0] idx;
        logic [48:0] dif;
        logic [39:0] sd;
        o   = '0;
        idx = td[19:0];
        sd  = td[203:164];
        if (idx == 20'd0) o.kind = esc_pkg::K_STEP;
        else if (idx == 20'd1) o.kind = esc_pkg::K_UNI;
        else if (idx == 20'd2) o.kind = esc_pkg::K_TRI;
        else o.kind = esc_pkg::K_NORM;
        o.d   = {td[67], td[67:20]} - {td[115], td[115:68]};
        dif   = {td[67], td[67:20]} - {td[163], td[163:116]};
        o.inv = ~dif[48];
        o.mag = dif[48] ? 48'(49'd0 - dif) : dif[47:0];
        o.sig = (sd == 40'd0) ? 40'd1 : sd;
        return o;
    endfunction

    // range checks, divider operands for ramp and normal z
    function automatic esc_pkg::t_item f_cls(input esc_pkg::t_item a, input logic [23:0] r);
        esc_pkg::t_item o;
        logic signed [48:0] ds;
        logic signed [48:0] r1;
        logic signed [48:0] r2;
        o   = a;
        ds  = signed'(a.d);
        r1  = signed'({25'd0, r});
        r2  = signed'({24'd0, r, 1'b0});
        o.quo = '0;
        case (a.kind)
            esc_pkg::K_STEP: begin
                o.done = 1'b1;
                o.res  = (ds < 0) ? 17'd0 : esc_pkg::ONE_Q16;
            end
            esc_pkg::K_UNI: begin
                if (ds <= 0) begin
                    o.done = 1'b1;
                    o.res  = 17'd0;
                end else if (ds >= r1) begin
                    o.done = 1'b1;
                    o.res  = esc_pkg::ONE_Q16;
                end
                o.rem = {24'd0, a.d[23:0], 16'd0} + {41'd0, r[23:1]};
                o.dvs = {24'd0, r};
            end
            esc_pkg::K_TRI: begin
                if (ds < 0) begin
                    o.done = 1'b1;
                    o.res  = 17'd0;
                end else if (ds < r1) begin
                    o.ev  = a.d[23:0];
                    o.inv = 1'b0;
                end else if (ds < r2) begin
                    o.ev  = 24'(r2 - ds);
                    o.inv = 1'b1;
                end else begin
                    o.done = 1'b1;
                    o.res  = esc_pkg::ONE_Q16;
                end
            end
            esc_pkg::K_NORM: begin
                o.sat = (a.mag >= {5'd0, a.sig, 3'd0});
                o.rem = {1'b0, a.mag[42:0], 20'd0};
                o.dvs = {8'd0, a.sig};
            end
            default: o = a;
        endcase
        return o;
    endfunction

    // triangle: e*e*2^15 + R*R/2 over R*R
    function automatic esc_pkg::t_item f_tri(input esc_pkg::t_item a, input logic [23:0] r);
        esc_pkg::t_item o;
        logic [47:0] ee;
        logic [47:0] rr;
        o  = a;
        ee = a.ev * a.ev;
        rr = r * r;
        if (a.kind == esc_pkg::K_TRI) begin
            o.rem = {1'b0, ee, 15'd0} + {17'd0, rr[47:1]};
            o.dvs = rr;
        end
        return o;
    endfunction

    // one restoring quotient bit
    function automatic esc_pkg::t_item f_div(input esc_pkg::t_item a, input int k);
        esc_pkg::t_item o;
        logic [79:0] sh;
        o  = a;
        sh = {32'd0, a.dvs} << k;
        if ({16'd0, a.rem} >= sh) begin
            o.rem = a.rem - sh[63:0];
            o.quo = a.quo | (31'd1 << k);
        end
        return o;
    endfunction

    // ramp results; normal x = z / sqrt(2)
    function automatic esc_pkg::t_item f_pst(input esc_pkg::t_item a);
        esc_pkg::t_item o;
        logic [23:0] z;
        logic [53:0] xm;
        o  = a;
        z  = a.sat ? 24'h800000 : {1'b0, a.quo[22:0]};
        xm = z * esc_pkg::INV_SQRT2 + 54'd536870912;
        o.x = xm[52:30];
        if (!a.done && a.kind == esc_pkg::K_UNI) begin
            o.res = a.quo[16:0];
        end else if (!a.done && a.kind == esc_pkg::K_TRI) begin
            o.res = a.inv ? (esc_pkg::ONE_Q16 - {1'b0, a.quo[15:0]}) : a.quo[16:0];
        end
        return o;
    endfunction

    // denominator 1 + p*x, reciprocal operands, x*x
    function automatic esc_pkg::t_item f_den(input esc_pkg::t_item a);
        esc_pkg::t_item o;
        logic [51:0] pm;
        logic [31:0] dn;
        logic [45:0] xx;
        o   = a;
        pm  = a.x * esc_pkg::P_Q30 + 52'd524288;
        dn  = 32'h40000000 + pm[51:20];
        xx  = a.x * a.x + 46'd524288;
        o.u   = xx[45:20];
        o.dvs = {16'd0, dn};
        o.rem = 64'h1000_0000_0000_0000 + {33'd0, dn[31:1]};
        o.quo = '0;
        return o;
    endfunction

    // Horner step: round(acc * q) + c, ties away from zero
    function automatic esc_pkg::t_item f_hrn(input esc_pkg::t_item a, input logic first,
                                            input logic signed [31:0] c);
        esc_pkg::t_item o;
        logic signed [31:0] ai;
        logic [31:0] ma;
        logic [61:0] pr;
        logic signed [31:0] rq;
        o  = a;
        ai = first ? esc_pkg::A5_Q30 : signed'(a.acc);
        ma = ai[31] ? 32'(-ai) : 32'(ai);
        pr = ma[30:0] * a.quo + 62'd536870912;
        rq = ai[31] ? -signed'(pr[61:30]) : signed'(pr[61:30]);
        o.acc = 32'(rq + c);
        return o;
    endfunction

    // clamp poly to [0,1]; x*x*log2(e)
    function automatic esc_pkg::t_item f_clp(input esc_pkg::t_item a);
        esc_pkg::t_item o;
        logic [56:0] vm;
        o = a;
        if (signed'(a.acc) < 0) o.acc = '0;
        else if (signed'(a.acc) > signed'({1'b0, esc_pkg::ONE_Q30})) o.acc = {1'b0, esc_pkg::ONE_Q30};
        vm   = a.u * esc_pkg::LOG2E_Q30 + 57'd524288;
        o.ip = vm[56:50];
        o.g  = vm[49:20];
        return o;
    endfunction

    // g = f * ln2
    function automatic esc_pkg::t_item f_g(input esc_pkg::t_item a);
        esc_pkg::t_item o;
        logic [59:0] gm;
        o   = a;
        gm  = a.g * esc_pkg::LN2_Q30 + 60'd536870912;
        o.g = gm[59:30];
        o.h = esc_pkg::ONE_Q30;
        return o;
    endfunction

    function automatic esc_pkg::t_item f_tmul(input esc_pkg::t_item a);
        esc_pkg::t_item o;
        logic [60:0] pm;
        o   = a;
        pm  = a.g * a.h + 61'd536870912;
        o.p = pm[60:30];
        return o;
    endfunction

    function automatic esc_pkg::t_item f_tdiv(input esc_pkg::t_item a, input int k);
        esc_pkg::t_item o;
        logic [62:0] pm;
        logic [62:0] qt;
        o   = a;
        pm  = a.p * esc_pkg::RECIP[k];
        qt  = pm >> esc_pkg::RSHF[k];
        o.h = esc_pkg::ONE_Q30 - qt[30:0];
        return o;
    endfunction

    // scale by 2^-ip with rounding
    function automatic esc_pkg::t_item f_shf(input esc_pkg::t_item a);
        esc_pkg::t_item o;
        logic [31:0] sm;
        o  = a;
        sm = ({1'b0, a.h} + (32'd1 << (a.ip - 7'd1))) >> a.ip;
        if (a.ip >= 7'd32) o.h = '0;
        else if (a.ip == 7'd0) o.h = a.h;
        else o.h = sm[30:0];
        return o;
    endfunction

    function automatic esc_pkg::t_item f_e(input esc_pkg::t_item a);
        esc_pkg::t_item o;
        logic [61:0] em;
        o     = a;
        em    = a.acc[30:0] * a.h + 62'd536870912;
        o.acc = em[61:30];
        return o;
    endfunction

    function automatic esc_pkg::t_item f_out(input esc_pkg::t_item a);
        esc_pkg::t_item o;
        logic [31:0] hs;
        o  = a;
        hs = a.acc + 32'd16384;
        if (a.kind == esc_pkg::K_NORM)
            o.res = a.inv ? (esc_pkg::ONE_Q16 - hs[31:15]) : hs[31:15];
        return o;
    endfunction

    // ---------------------------------------------------------------
    // pipeline
    // ---------------------------------------------------------------
    logic [23:0]          r_max_delay;
    logic [esc_pkg::NST-1:0] r_vld;
    esc_pkg::t_item       r_p [esc_pkg::NST];
    esc_pkg::t_item       n_p [esc_pkg::NST];
    logic                 en;

    // global advance: halt only when the output register is full and blocked
    assign en            = ~r_vld[esc_pkg::ST_OUT] | m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[esc_pkg::ST_OUT];
    assign m_axis_tdata  = {7'd0, r_p[esc_pkg::ST_OUT].res};

    assign n_p[esc_pkg::ST_S0]  = f_s0(s_axis_tdata);
    assign n_p[esc_pkg::ST_CLS] = f_cls(r_p[esc_pkg::ST_S0], r_max_delay);
    assign n_p[esc_pkg::ST_TRI] = f_tri(r_p[esc_pkg::ST_CLS], r_max_delay);

    // z, ramp and triangle quotients share the first divider
    for (genvar gi = 0; gi < esc_pkg::N_D1; gi++) begin : g_div1
        assign n_p[esc_pkg::ST_D1 + gi] =
            f_div(r_p[esc_pkg::ST_D1 + gi - 1], esc_pkg::N_D1 - 1 - gi);
    end

    assign n_p[esc_pkg::ST_PST] = f_pst(r_p[esc_pkg::ST_PST - 1]);
    assign n_p[esc_pkg::ST_DEN] = f_den(r_p[esc_pkg::ST_PST]);

    // q = 2^60 / den, rounded
    for (genvar gi = 0; gi < esc_pkg::N_D2; gi++) begin : g_div2
        assign n_p[esc_pkg::ST_D2 + gi] =
            f_div(r_p[esc_pkg::ST_D2 + gi - 1], esc_pkg::N_D2 - 1 - gi);
    end

    for (genvar gi = 0; gi < esc_pkg::N_HRN; gi++) begin : g_hrn
        assign n_p[esc_pkg::ST_HRN + gi] =
            f_hrn(r_p[esc_pkg::ST_HRN + gi - 1], (gi == 0), esc_pkg::HRN_ADD[gi]);
    end

    assign n_p[esc_pkg::ST_CLP] = f_clp(r_p[esc_pkg::ST_CLP - 1]);
    assign n_p[esc_pkg::ST_G]   = f_g(r_p[esc_pkg::ST_CLP]);

    // nested series for exp(-g), k = 10 down to 1
    for (genvar gi = 0; gi < esc_pkg::N_TAY; gi++) begin : g_tay
        assign n_p[esc_pkg::ST_TAY + 2 * gi] =
            f_tmul(r_p[esc_pkg::ST_TAY + 2 * gi - 1]);
        assign n_p[esc_pkg::ST_TAY + 2 * gi + 1] =
            f_tdiv(r_p[esc_pkg::ST_TAY + 2 * gi], esc_pkg::N_TAY - gi);
    end

    assign n_p[esc_pkg::ST_SHF] = f_shf(r_p[esc_pkg::ST_SHF - 1]);
    assign n_p[esc_pkg::ST_E]   = f_e(r_p[esc_pkg::ST_SHF]);
    assign n_p[esc_pkg::ST_OUT] = f_out(r_p[esc_pkg::ST_E]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_delay <= esc_pkg::DELAY_RST;
        end else if (i_cfg_we) begin
            r_max_delay <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[esc_pkg::NST-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p <= n_p;
        end
    end

`ifndef SYNTHESIS
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[esc_pkg::ST_OUT] |-> r_p[esc_pkg::ST_OUT].res <= esc_pkg::ONE_Q16)
        else $error("result above one");

    a_step_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[esc_pkg::ST_OUT] && r_p[esc_pkg::ST_OUT].kind == esc_pkg::K_STEP |->
        r_p[esc_pkg::ST_OUT].res == 17'd0 || r_p[esc_pkg::ST_OUT].res == esc_pkg::ONE_Q16)
        else $error("step result not 0 or 1");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[esc_pkg::ST_CLP] |-> r_p[esc_pkg::ST_CLP].acc <= {1'b0, esc_pkg::ONE_Q30})
        else $error("poly clamp out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved during stall");
`endif

endmodule

// ----- sim/event_start_cdf_unit_tb.sv -----
// Testbench: event start probability unit checked against a bit-exact predictor
`timescale 1ns / 1ps

module event_start_cdf_unit_tb;

    localparam longint unsigned Q30_ONE   = 64'd1073741824;
    localparam longint unsigned INV_RT2   = 64'd759250125;
    localparam longint unsigned P_COEF    = 64'd351748265;
    localparam longint          C_A1      = 64'sd273621191;
    localparam longint          C_A2      = -64'sd305476044;
    localparam longint          C_A3      = 64'sd1526231383;
    localparam longint          C_A4      = -64'sd1560310108;
    localparam longint          C_A5      = 64'sd1139675401;
    localparam longint unsigned LOG2E_C   = 64'd1549082005;
    localparam longint unsigned LN2_C     = 64'd744261118;
    localparam longint unsigned Z_SAT     = 64'd8 << 20;
    localparam logic [19:0]     IDX_STEP  = 20'd0;
    localparam logic [19:0]     IDX_UNI   = 20'd1;
    localparam logic [19:0]     IDX_TRI   = 20'd2;
    localparam logic [19:0]     IDX_NORM  = 20'd3;
    localparam logic [19:0]     IDX_MAX   = 20'hFFFFF;
    localparam longint          T_MIN     = -(64'sd1 <<< 47);
    localparam longint          T_MAX     = (64'sd1 <<< 47) - 1;
    localparam int              LATENCY   = 89;

    typedef struct {
        logic [19:0] idx;
        longint      t;
        longint      ts;
        longint      mu;
        logic [39:0] sig;
    } t_req;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [esc_pkg::IN_W-1:0]   s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [esc_pkg::OUT_W-1:0]  m_axis_tdata;
    logic                       i_cfg_we = 1'b0;
    logic [23:0]                i_cfg_wdata = '0;

    // predictor copy of the delay width register
    longint unsigned       delay_ns = 64'd10000000;
    logic [16:0]           prob_q[$];
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    hold_left = 0;
    int                    mismatches = 0;
    int                    results_seen = 0;
    int                    requests_sent = 0;

    always #6 i_clk = ~i_clk;

    event_start_cdf_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // ---------------- predictor ----------------

    function automatic longint q30_mul(longint a, longint b);
        longint unsigned ma, mb;
        longint          r;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        r = (ma * mb + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    // exp(-u) with u in Q.20, answer in Q0.30, via 2^-(u*log2 e)
    function automatic longint unsigned exp_decay(longint unsigned u);
        longint unsigned v, ip, f, g, h;
        v = (u * LOG2E_C + (64'd1 << 19)) >> 20;
        ip = v >> 30;
        f = v & (Q30_ONE - 1);
        g = (f * LN2_C + (64'd1 << 29)) >> 30;
        h = Q30_ONE;
        for (int k = 10; k >= 1; k--) begin
            h = Q30_ONE - ((g * h + (64'd1 << 29)) >> 30) / k;
        end
        if (ip >= 32) return 0;
        if (ip == 0) return h;
        return (h + (64'd1 << (ip - 1))) >> ip;
    endfunction

    function automatic logic [16:0] gauss_prob(longint diff, longint unsigned sigma);
        longint unsigned mag, z, x, den, q, e, tail, half;
        longint          acc;
        mag = diff < 0 ? -diff : diff;
        if (sigma == 0) sigma = 1;
        if (mag >= 8 * sigma) z = Z_SAT;
        else z = (mag << 20) / sigma;
        x = (z * INV_RT2 + (64'd1 << 29)) >> 30;
        den = Q30_ONE + ((x * P_COEF + (64'd1 << 19)) >> 20);
        q = ((64'd1 << 60) + den / 2) / den;
        acc = C_A5;
        acc = q30_mul(acc, q) + C_A4;
        acc = q30_mul(acc, q) + C_A3;
        acc = q30_mul(acc, q) + C_A2;
        acc = q30_mul(acc, q) + C_A1;
        acc = q30_mul(acc, q);
        if (acc < 0) acc = 0;
        if (acc > longint'(Q30_ONE)) acc = Q30_ONE;
        e = exp_decay((x * x + (64'd1 << 19)) >> 20);
        tail = (longint'(acc) * e + (64'd1 << 29)) >> 30;
        half = (tail + (64'd1 << 14)) >> 15;
        return diff >= 0 ? 17'(65536 - half) : 17'(half);
    endfunction

    function automatic longint unsigned tri_rise(longint unsigned d, longint unsigned r);
        longint unsigned rr;
        rr = r * r;
        return (d * d * 32768 + rr / 2) / rr;
    endfunction

    function automatic logic [16:0] start_prob(t_req rq);
        longint d, r;
        d = rq.t - rq.ts;
        r = delay_ns;
        if (rq.idx == IDX_STEP) return d < 0 ? 17'd0 : esc_pkg::ONE_Q16;
        if (rq.idx == IDX_UNI) begin
            if (d <= 0) return 17'd0;
            if (d < r) return 17'((longint'(d) * 65536 + r / 2) / r);
            return esc_pkg::ONE_Q16;
        end
        if (rq.idx == IDX_TRI) begin
            if (d < 0) return 17'd0;
            if (d < r) return 17'(tri_rise(d, r));
            if (d < 2 * r) return 17'(65536 - tri_rise(2 * r - d, r));
            return esc_pkg::ONE_Q16;
        end
        return gauss_prob(rq.t - rq.mu, rq.sig);
    endfunction

    // ---------------- result side ----------------

    // long hold-off counter, armed by the pressure test
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        logic [16:0] want;
        if (m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (prob_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result cdf=%0d", m_axis_tdata[16:0]);
            end else begin
                want = prob_q.pop_front();
                if (m_axis_tdata[16:0] !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("cdf_value expected %0d got %0d", want, m_axis_tdata[16:0]);
                end
            end
        end
        m_axis_tready <= (hold_left > 1) ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------- request side ----------------

    task automatic send_req(t_req rq);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, rq.sig, rq.mu[47:0], rq.ts[47:0], rq.t[47:0], rq.idx};
        do @(posedge i_clk); while (!s_axis_tready);
        prob_q.push_back(start_prob(rq));
        requests_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (prob_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_delay(logic [23:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        delay_ns = val;
    endtask

    function automatic t_req mk(logic [19:0] idx, longint t, longint ts, longint mu,
                                logic [39:0] sig);
        t_req rq;
        rq.idx = idx; rq.t = t; rq.ts = ts; rq.mu = mu; rq.sig = sig;
        return rq;
    endfunction

    function automatic longint rnd48();
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        return longint'($signed(v));
    endfunction

    // step, uniform and triangle edges around the current delay width
    task automatic test_piecewise_edges();
        longint r, b;
        r = delay_ns;
        b = rnd48() >>> 2;
        send_req(mk(IDX_STEP, b - 1, b, 0, 1));
        send_req(mk(IDX_STEP, b, b, 0, 1));
        send_req(mk(IDX_STEP, T_MIN, T_MAX, 0, 1));
        send_req(mk(IDX_STEP, T_MAX, T_MIN, 0, 1));
        send_req(mk(IDX_UNI, b, b, 0, 1));       // boundary at ideal start gives zero
        send_req(mk(IDX_UNI, b + 1, b, 0, 1));
        send_req(mk(IDX_UNI, b + r - 1, b, 0, 1));
        send_req(mk(IDX_UNI, b + r, b, 0, 1));
        send_req(mk(IDX_TRI, b - 1, b, 0, 1));
        send_req(mk(IDX_TRI, b, b, 0, 1));
        send_req(mk(IDX_TRI, b + r - 1, b, 0, 1));
        send_req(mk(IDX_TRI, b + r, b, 0, 1));
        send_req(mk(IDX_TRI, b + 2 * r - 1, b, 0, 1));
        send_req(mk(IDX_TRI, b + 2 * r, b, 0, 1));
        send_req(mk(IDX_TRI, T_MAX, T_MIN, 0, 1));
    endtask

    // normal branch: center, saturation, zero deviation, largest index
    task automatic test_normal_edges();
        send_req(mk(IDX_NORM, 0, 0, 0, 40'd1000));
        send_req(mk(IDX_NORM, 7999, 0, 0, 40'd1000));
        send_req(mk(IDX_NORM, 8000, 0, 0, 40'd1000));
        send_req(mk(IDX_NORM, -8000, 0, 0, 40'd1000));
        send_req(mk(IDX_NORM, 5, 0, 0, 40'd0));          // zero deviation as one
        send_req(mk(IDX_MAX, -1234, 0, 0, 40'd1000));
        send_req(mk(IDX_MAX, T_MAX, 0, T_MIN, 40'hFFFFFFFFFF));
        send_req(mk(IDX_NORM, T_MIN, 0, T_MAX, 40'd1));
        send_req(mk(IDX_NORM, 1, 0, 0, 40'hFFFFFFFFFF));
    endtask

    function automatic t_req rnd_req();
        t_req        rq;
        int          pick;
        longint      r, span;
        logic [39:0] s;
        r = delay_ns;
        pick = $urandom_range(99);
        rq = mk(20'($urandom), rnd48(), rnd48(), rnd48(), 40'({$urandom, $urandom}));
        if (pick < 45) begin
            // piecewise kinds with the offset landing around the interesting region
            rq.idx = 20'($urandom_range(2));
            rq.ts = rnd48() >>> 2;
            rq.t = rq.ts + $signed(longint'($urandom_range(2 * r + 4))) - 2;
        end else if (pick < 80) begin
            // normal with the offset within ten deviations
            s = 40'({$urandom, $urandom} >> $urandom_range(39));
            if (s == 0) s = 1;
            span = 10 * longint'(s);
            rq.idx = IDX_NORM + ($urandom_range(1) ? 20'($urandom_range(60)) : 20'($urandom));
            rq.sig = s;
            rq.mu = rnd48() >>> 2;
            rq.t = rq.mu + longint'({$urandom, $urandom} % (2 * span + 1)) - span;
        end
        return rq;
    endfunction

    task automatic test_random(int count);
        repeat (count) send_req(rnd_req());
    endtask

    // receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        hold_left = 400;
        repeat (150) send_req(rnd_req());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_piecewise_edges();                  // reset value of the delay width
        test_normal_edges();
        drain();

        write_delay(24'd1);
        test_piecewise_edges();
        drain();
        write_delay(24'hFFFFFF);
        test_piecewise_edges();
        drain();

        send_idle_pct = 18; recv_idle_pct = 47;
        write_delay(24'($urandom_range(1000, 1)));
        test_random(330);
        drain();

        send_idle_pct = 47; recv_idle_pct = 18;
        write_delay(24'($urandom_range(24'hFFFFFF, 1)));
        test_random(330);
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        write_delay(24'($urandom_range(200, 2)));
        test_random(280);
        test_backpressure();
        drain();

        $display("Covered step, uniform, triangular and normal requests: %0d sent, %0d checked",
                 requests_sent, results_seen);
        $display("under six delay settings, idle mixes and a long output hold-off.");
        if (mismatches == 0 && prob_q.size() == 0)
            $display("event_start_cdf_unit: match");
        else
            $display("event_start_cdf_unit: mismatch");
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("event_start_cdf_unit: mismatch");
        $finish;
    end

endmodule
